### rtl/tdc_pkg.sv
`default_nettype none

package tdc_pkg;

  // Segment and field geometry
  localparam int unsigned MAX_LINE = 64;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned COEF_W   = 30;
  localparam int unsigned DIAG_W   = 32;
  localparam int unsigned RATIO_W  = 32;
  localparam int unsigned FRAC_R   = 30;
  localparam int unsigned PROD_W   = COEF_W + RATIO_W;
  localparam int unsigned DVD_W    = COEF_W + FRAC_R + 1;
  localparam int unsigned QUO_W    = RATIO_W + 1;

  // Stream packing
  localparam int unsigned IN_W  = 104;
  localparam int unsigned OUT_W = 72;

  localparam logic [DIAG_W-1:0]  ONE_Q16   = 32'h0001_0000;
  localparam logic [RATIO_W-1:0] RATIO_SAT = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } tdc_state_e;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DIAG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [RATIO_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/tdc_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, quotient saturated to 2^31.
module tdc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tdc_pkg::div_req_t req_i,
  output tdc_pkg::div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(tdc_pkg::QUO_W);
  localparam int unsigned HI_W  = tdc_pkg::DVD_W - tdc_pkg::QUO_W;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [tdc_pkg::DIAG_W-1:0]    rem_q, rem_d;
  logic [tdc_pkg::DIAG_W-1:0]    dvs_q, dvs_d;
  logic [tdc_pkg::QUO_W-1:0]     num_q, num_d;
  logic [tdc_pkg::QUO_W-1:0]     quo_q, quo_d;
  logic [tdc_pkg::RATIO_W-1:0]   res_q, res_d;
  logic [tdc_pkg::DIAG_W:0]      rem_sh;
  logic [tdc_pkg::QUO_W-1:0]     quo_nx;
  logic                          fits;
  logic                          too_big;

  always_comb begin
    rem_sh  = {rem_q, num_q[tdc_pkg::QUO_W-1]};
    fits    = rem_sh >= {1'b0, dvs_q};
    quo_nx  = {quo_q[tdc_pkg::QUO_W-2:0], fits};
    too_big = {{(tdc_pkg::DIAG_W-HI_W){1'b0}}, req_i.dividend[tdc_pkg::DVD_W-1 -: HI_W]}
              >= req_i.divisor;

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    num_d  = num_q;
    quo_d  = quo_q;
    res_d  = res_q;

    if (req_i.start) begin
      dvs_d = req_i.divisor;
      rem_d = {{(tdc_pkg::DIAG_W-HI_W){1'b0}}, req_i.dividend[tdc_pkg::DVD_W-1 -: HI_W]};
      num_d = req_i.dividend[tdc_pkg::QUO_W-1:0];
      quo_d = '0;
      cnt_d = CNT_W'(tdc_pkg::QUO_W - 1);
      if (req_i.divisor == '0) begin
        // zero divisor: zero over zero gives zero, anything else saturates
        done_d = 1'b1;
        busy_d = 1'b0;
        res_d  = (req_i.dividend == '0) ? '0 : tdc_pkg::RATIO_SAT;
      end else if (too_big) begin
        done_d = 1'b1;
        busy_d = 1'b0;
        res_d  = tdc_pkg::RATIO_SAT;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = fits ? tdc_pkg::DIAG_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[tdc_pkg::DIAG_W-1:0];
      num_d = num_q << 1;
      quo_d = quo_nx;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = (quo_nx > {1'b0, tdc_pkg::RATIO_SAT}) ? tdc_pkg::RATIO_SAT
                                                       : quo_nx[tdc_pkg::RATIO_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    num_q <= num_d;
    quo_q <= quo_d;
    res_q <= res_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = res_q;

endmodule

`default_nettype wire

### rtl/tridiagonal_thomas_coefficients.sv
`default_nettype none

// Channel  | Dir | Beat contents
// s_axis   | in  | tdata: coupling[29:0], decay_term[59:30], line_length[66:60],
//          |     |        carry_ratio[98:67], zero pad; tuser: is_first; tlast: is_last
// m_axis   | out | tdata: node_index[5:0], diagonal[37:6], ratio[69:38], zero pad;
//          |     |        tlast: last_node
//
// One input beat yields line_length result beats (zero taken as one, clamped to 64).
// Each node steps through multiply, sum/saturate, divider load, 33 divider steps
// plus result, emit; a zero or overflowing divisor skips the divider steps.
// A new input beat is taken only while idle, after the last node of an item is emitted.
// Reset (rst_ni low, asynchronous) returns to idle and drops any pending result beat.
// A stalled output holds the sequencer in its emit step once the output register is full;
// the last result may wait in the output register while the next input beat is taken.
module tridiagonal_thomas_coefficients (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // coupling, decay_term, line_length, carry_ratio (low bit up)
  input  logic [tdc_pkg::IN_W-1:0]  s_axis_tdata_i,
  // is_first
  input  logic                      s_axis_tuser_i,
  // is_last
  input  logic                      s_axis_tlast_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // node_index, diagonal, ratio (low bit up)
  output logic [tdc_pkg::OUT_W-1:0] m_axis_tdata_o,
  // last_node
  output logic                      m_axis_tlast_o
);

  localparam int unsigned C1_LO  = 0;
  localparam int unsigned C2_LO  = C1_LO + tdc_pkg::COEF_W;
  localparam int unsigned LEN_LO = C2_LO + tdc_pkg::COEF_W;
  localparam int unsigned CR_LO  = LEN_LO + tdc_pkg::LEN_W;
  localparam int unsigned OUT_PAD =
      tdc_pkg::OUT_W - tdc_pkg::IDX_W - tdc_pkg::DIAG_W - tdc_pkg::RATIO_W;
  localparam int unsigned SUM_W = tdc_pkg::DIAG_W + 2;

  tdc_pkg::tdc_state_e state_q, state_d;

  logic                         in_fire;
  logic                         out_free;
  logic                         emit_go;
  logic                         div_start;
  logic                         use_fold;
  logic                         at_last;

  logic [tdc_pkg::COEF_W-1:0]   c1_q, c2_q;
  logic                         first_q, last_q;
  logic [tdc_pkg::IDX_W-1:0]    lastidx_q, lastidx_d;
  logic [tdc_pkg::IDX_W-1:0]    idx_q;
  logic [tdc_pkg::RATIO_W-1:0]  prev_q;
  logic [tdc_pkg::PROD_W-1:0]   prod_q;
  logic                         neg_q;
  logic [tdc_pkg::DIAG_W-1:0]   diag_q, diag_d;

  logic [tdc_pkg::LEN_W-1:0]    len_in, len_c;
  logic [tdc_pkg::RATIO_W-1:0]  mag;
  logic [tdc_pkg::PROD_W-1:0]   prod_rnd;
  logic [tdc_pkg::DIAG_W-1:0]   fold_term;
  logic [tdc_pkg::DIAG_W-1:0]   diag_edge, diag_inner, diag_base;
  logic [SUM_W-1:0]             dsum;

  logic                         out_valid_q, out_valid_d;
  logic [tdc_pkg::IDX_W-1:0]    out_idx_q;
  logic [tdc_pkg::DIAG_W-1:0]   out_diag_q;
  logic [tdc_pkg::RATIO_W-1:0]  out_ratio_q;
  logic                         out_last_q;

  tdc_pkg::div_req_t div_req;
  tdc_pkg::div_rsp_t div_rsp;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign at_last  = idx_q == lastidx_q;
  assign use_fold = (idx_q != '0) || !first_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tdc_pkg::ST_IDLE: if (s_axis_tvalid_i) state_d = tdc_pkg::ST_MUL;
      tdc_pkg::ST_MUL:  state_d = tdc_pkg::ST_SUM;
      tdc_pkg::ST_SUM:  state_d = tdc_pkg::ST_LOAD;
      tdc_pkg::ST_LOAD: state_d = tdc_pkg::ST_DIV;
      tdc_pkg::ST_DIV:  if (div_rsp.done) state_d = tdc_pkg::ST_EMIT;
      tdc_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = at_last ? tdc_pkg::ST_IDLE : tdc_pkg::ST_MUL;
        end
      end
      default: state_d = tdc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready_o = state_q == tdc_pkg::ST_IDLE;
    div_start       = state_q == tdc_pkg::ST_LOAD;
    emit_go         = (state_q == tdc_pkg::ST_EMIT) && out_free;
  end

  // Line length: zero counts as one node, clamp to the longest line
  always_comb begin
    len_in = s_axis_tdata_i[LEN_LO +: tdc_pkg::LEN_W];
    if (len_in == '0) begin
      len_c = tdc_pkg::LEN_W'(1);
    end else if (len_in > tdc_pkg::LEN_W'(tdc_pkg::MAX_LINE)) begin
      len_c = tdc_pkg::LEN_W'(tdc_pkg::MAX_LINE);
    end else begin
      len_c = len_in;
    end
    lastidx_d = tdc_pkg::IDX_W'(len_c - tdc_pkg::LEN_W'(1));
  end

  // Fold magnitude of the previous ratio; node 0 of a first segment folds nothing
  always_comb begin
    if (!use_fold) begin
      mag = '0;
    end else if (prev_q[tdc_pkg::RATIO_W-1]) begin
      mag = ~prev_q + tdc_pkg::RATIO_W'(1);
    end else begin
      mag = prev_q;
    end
  end

  // Round the Q.46 product half up to Q16.16, pick the starting diagonal, saturate
  always_comb begin
    prod_rnd   = prod_q + (tdc_pkg::PROD_W'(1) << (tdc_pkg::FRAC_R - 1));
    fold_term  = prod_rnd[tdc_pkg::PROD_W-1:tdc_pkg::FRAC_R];
    diag_edge  = tdc_pkg::ONE_Q16 + tdc_pkg::DIAG_W'(c1_q) + tdc_pkg::DIAG_W'(c2_q);
    diag_inner = diag_edge + tdc_pkg::DIAG_W'(c1_q);

    priority if (first_q && (lastidx_q == '0)) begin
      diag_base = tdc_pkg::ONE_Q16 + tdc_pkg::DIAG_W'(c2_q);
    end else if ((first_q && (idx_q == '0)) || (last_q && at_last)) begin
      diag_base = diag_edge;
    end else begin
      diag_base = diag_inner;
    end

    dsum = neg_q ? (SUM_W'(diag_base) - SUM_W'(fold_term))
                 : (SUM_W'(diag_base) + SUM_W'(fold_term));

    priority if (dsum[SUM_W-1]) begin
      diag_d = '0;
    end else if (dsum[SUM_W-2]) begin
      diag_d = '1;
    end else begin
      diag_d = dsum[tdc_pkg::DIAG_W-1:0];
    end
  end

  // Divider request: (c1 << 30) + diag/2, so the quotient comes out rounded
  always_comb begin
    div_req.start    = div_start;
    div_req.dividend = tdc_pkg::DVD_W'({c1_q, {tdc_pkg::FRAC_R{1'b0}}})
                     + tdc_pkg::DVD_W'(diag_q[tdc_pkg::DIAG_W-1:1]);
    div_req.divisor  = diag_q;
  end

  tdc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_go) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      c1_q      <= s_axis_tdata_i[C1_LO +: tdc_pkg::COEF_W];
      c2_q      <= s_axis_tdata_i[C2_LO +: tdc_pkg::COEF_W];
      lastidx_q <= lastidx_d;
      first_q   <= s_axis_tuser_i;
      last_q    <= s_axis_tlast_i;
      prev_q    <= s_axis_tdata_i[CR_LO +: tdc_pkg::RATIO_W];
      idx_q     <= '0;
    end else begin
      // carry the new ratio to the next node
      if ((state_q == tdc_pkg::ST_DIV) && div_rsp.done) begin
        prev_q <= ~div_rsp.quotient + tdc_pkg::RATIO_W'(1);
      end
      if (emit_go) begin
        idx_q <= idx_q + tdc_pkg::IDX_W'(1);
      end
    end
    if (state_q == tdc_pkg::ST_MUL) begin
      prod_q <= tdc_pkg::PROD_W'(c1_q) * tdc_pkg::PROD_W'(mag);
      neg_q  <= use_fold && prev_q[tdc_pkg::RATIO_W-1];
    end
    if (state_q == tdc_pkg::ST_SUM) begin
      diag_q <= diag_d;
    end
    if (emit_go) begin
      out_idx_q   <= idx_q;
      out_diag_q  <= diag_q;
      out_ratio_q <= prev_q;
      out_last_q  <= at_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD{1'b0}}, out_ratio_q, out_diag_q, out_idx_q};
  assign m_axis_tlast_o  = out_last_q;

  // The divider only answers while the sequencer waits on it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == tdc_pkg::ST_DIV))
    else $error("divider result outside the divide step");

  // Ratios are -c1/diag, never positive
  a_ratio_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_ratio_q[tdc_pkg::RATIO_W-1] || (out_ratio_q == '0)))
    else $error("positive ratio emitted");

  // Node counter stays within the segment
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != tdc_pkg::ST_IDLE) |-> (idx_q <= lastidx_q))
    else $error("node index past segment end");

  // Emitting the last node ends the item
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && at_last) |=> (state_q == tdc_pkg::ST_IDLE) && m_axis_tlast_o)
    else $error("sequencer kept running after last node");

endmodule

`default_nettype wire
